>>> hw/rtl/box_sdf_query_macros.svh
// assertion helpers used by box_sdf_query
`ifndef BOX_SDF_QUERY_MACROS_SVH
`define BOX_SDF_QUERY_MACROS_SVH

// property checked on every rising clock edge outside reset
`define BSQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition that must be followed by another in the next cycle
`define BSQ_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) else $error(msg);

`endif

>>> hw/rtl/bsq_pkg.sv
// ----------------------------------------------------------------------------
// bsq_pkg
// Widths, codes and beat types of the box distance query pipeline.
// ----------------------------------------------------------------------------
package bsq_pkg;

    localparam int COORD_W    = 32;
    localparam int FRAC_BITS  = 16;
    localparam int GRAD_FRAC  = 14;
    localparam int GRAD_W     = GRAD_FRAC + 2;
    localparam int HALF_W     = COORD_W - 1;
    localparam int P_W        = COORD_W + 1;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int SUM_W      = 2 * COORD_W + 2;
    localparam int ROOT_W     = COORD_W + 1;
    localparam int REM_W      = ROOT_W + 1;
    localparam int ACC_W      = GRAD_FRAC + 1;
    localparam int NUM_AXES   = 3;
    localparam int AXIS_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int GRAD_ONE   = 1 << GRAD_FRAC;

    localparam logic [HALF_W-1:0]  HALF_RESET = HALF_W'(1 << FRAC_BITS);
    localparam logic [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_HALF_X   = 3'd3,
        REG_HALF_Y   = 3'd4,
        REG_HALF_Z   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic                      want_gradient;
        logic                      want_closest;
    } t_query;

    typedef struct packed {
        logic signed [COORD_W-1:0] distance;
        logic signed [GRAD_W-1:0]  grad_x;
        logic signed [GRAD_W-1:0]  grad_y;
        logic signed [GRAD_W-1:0]  grad_z;
        logic signed [COORD_W-1:0] near_x;
        logic signed [COORD_W-1:0] near_y;
        logic signed [COORD_W-1:0] near_z;
        logic                      near_valid;
    } t_result;

    // control travelling with each beat
    typedef struct packed {
        logic              valid;
        logic              want_grad;
        logic              want_near;
        logic              outside;
        logic [AXIS_W-1:0] axis;
    } t_ctl;

    // geometry travelling with each beat
    typedef struct packed {
        logic [NUM_AXES-1:0][P_W-1:0]     p;
        logic [NUM_AXES-1:0][COORD_W-1:0] o;
        logic [COORD_W-1:0]               dq;
    } t_side;

endpackage

>>> hw/rtl/bsq_stream_if.sv
// ----------------------------------------------------------------------------
// bsq_stream_if
// Valid/ready channel carrying one beat of a given payload type.
// ----------------------------------------------------------------------------
interface bsq_stream_if #(parameter type t_data = logic);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/box_sdf_query.sv
// ----------------------------------------------------------------------------
// box_sdf_query
// Signed distance, unit gradient and closest point of a query against a box.
// ----------------------------------------------------------------------------
// One query beat is taken every cycle in which the stages advance. Each
// beat passes four front stages (offset, excess, squares, sum), a row of 33
// square-root cells producing one root bit each, one rounding stage, a row
// of 15 divider cells producing one gradient bit each for all three axes,
// and the output register. All stages advance together whenever the output
// register is empty or its beat is being taken. The user must write box
// registers only while no query is in flight; the block does not enforce it.
module box_sdf_query (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    bsq_stream_if.sink                        i_query,
    bsq_stream_if.source                      o_result,
    input  logic                              i_cfg_we,
    input  logic [bsq_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bsq_pkg::COORD_W-1:0]       i_cfg_data
);
    import bsq_pkg::*;

    `include "box_sdf_query_macros.svh"

    logic [NUM_AXES-1:0][COORD_W-1:0] r_center;
    logic [NUM_AXES-1:0][HALF_W-1:0]  r_half;
    logic [NUM_AXES-1:0][COORD_W-1:0] point;
    logic                             en;
    t_ctl                             in_ctl;

    t_ctl              rt_ctl  [ROOT_W+1];
    t_side             rt_side [ROOT_W+1];
    logic [SUM_W-1:0]  rt_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] rt_root [ROOT_W+1];

    t_ctl                            dv_ctl  [ACC_W+1];
    t_side                           dv_side [ACC_W+1];
    logic [ROOT_W-1:0]               dv_n    [ACC_W+1];
    logic [NUM_AXES-1:0][REM_W-1:0]  dv_rem  [ACC_W+1];
    logic [NUM_AXES-1:0][ACC_W-1:0]  dv_acc  [ACC_W+1];

    t_ctl              r_rn_ctl;
    t_side             r_rn_side;
    logic [ROOT_W-1:0] r_rn_n;

    // box registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= '0;
            r_half   <= {NUM_AXES{HALF_RESET}};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CENTER_X: r_center[AXIS_X] <= i_cfg_data;
                REG_CENTER_Y: r_center[AXIS_Y] <= i_cfg_data;
                REG_CENTER_Z: r_center[AXIS_Z] <= i_cfg_data;
                REG_HALF_X:   r_half[AXIS_X]   <= i_cfg_data[HALF_W-1:0];
                REG_HALF_Y:   r_half[AXIS_Y]   <= i_cfg_data[HALF_W-1:0];
                REG_HALF_Z:   r_half[AXIS_Z]   <= i_cfg_data[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline moves when the output register can take a beat
    assign en             = !o_result.valid || o_result.ready;
    assign i_query.ready  = en;

    always_comb begin
        in_ctl           = '0;
        in_ctl.valid     = i_query.valid;
        in_ctl.want_grad = i_query.data.want_gradient;
        in_ctl.want_near = i_query.data.want_closest;
        point[AXIS_X]    = i_query.data.point_x;
        point[AXIS_Y]    = i_query.data.point_y;
        point[AXIS_Z]    = i_query.data.point_z;
    end

    bsq_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_ctl    (in_ctl),
        .i_point  (point),
        .i_center (r_center),
        .i_half   (r_half),
        .o_ctl    (rt_ctl[0]),
        .o_side   (rt_side[0]),
        .o_sum    (rt_rem[0])
    );

    assign rt_root[0] = '0;

    // square root, most significant bit first
    for (genvar j = 0; j < ROOT_W; j++) begin : g_root
        bsq_root_cell #(.BIT(COORD_W - j)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (rt_ctl[j]),
            .i_side  (rt_side[j]),
            .i_rem   (rt_rem[j]),
            .i_root  (rt_root[j]),
            .o_ctl   (rt_ctl[j+1]),
            .o_side  (rt_side[j+1]),
            .o_rem   (rt_rem[j+1]),
            .o_root  (rt_root[j+1])
        );
    end

    // round the root to nearest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rn_ctl.valid <= 1'b0;
        end else if (en) begin
            r_rn_ctl <= rt_ctl[ROOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rn_side <= rt_side[ROOT_W];
            r_rn_n    <= rt_root[ROOT_W]
                       + ROOT_W'(rt_rem[ROOT_W] > SUM_W'(rt_root[ROOT_W]));
        end
    end

    assign dv_ctl[0]  = r_rn_ctl;
    assign dv_side[0] = r_rn_side;
    assign dv_n[0]    = r_rn_n;
    assign dv_rem[0]  = '0;
    assign dv_acc[0]  = '0;

    // gradient division, one quotient bit per cell
    for (genvar j = 0; j < ACC_W; j++) begin : g_div
        bsq_div_cell #(.FIRST(j == 0)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (dv_ctl[j]),
            .i_side  (dv_side[j]),
            .i_n     (dv_n[j]),
            .i_rem   (dv_rem[j]),
            .i_acc   (dv_acc[j]),
            .o_ctl   (dv_ctl[j+1]),
            .o_side  (dv_side[j+1]),
            .o_n     (dv_n[j+1]),
            .o_rem   (dv_rem[j+1]),
            .o_acc   (dv_acc[j+1])
        );
    end

    bsq_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_ctl    (dv_ctl[ACC_W]),
        .i_side   (dv_side[ACC_W]),
        .i_n      (dv_n[ACC_W]),
        .i_rem    (dv_rem[ACC_W]),
        .i_acc    (dv_acc[ACC_W]),
        .i_center (r_center),
        .i_half   (r_half),
        .o_valid  (o_result.valid),
        .o_data   (o_result.data)
    );

    // checks
    `BSQ_ASSERT(a_ready_only_stalled, (!i_query.ready |-> o_result.valid), "input stalled with empty output")
    `BSQ_ASSERT_NEXT(a_round_moves, (rt_ctl[ROOT_W].valid && en), dv_ctl[0].valid, "beat lost in rounding stage")
    `BSQ_ASSERT(a_inside_grad_axis, ((o_result.valid && ($signed(o_result.data.distance) <= 0)) |-> ((o_result.data.grad_y == 0 && o_result.data.grad_z == 0) || (o_result.data.grad_x == 0 && o_result.data.grad_z == 0) || (o_result.data.grad_x == 0 && o_result.data.grad_y == 0))), "inside gradient not on one axis")
    `BSQ_ASSERT(a_grad_range, (o_result.valid |-> ($signed(o_result.data.grad_x) <= GRAD_ONE && $signed(o_result.data.grad_x) >= -GRAD_ONE)), "gradient x beyond unit")
    `BSQ_ASSERT(a_near_zero, ((o_result.valid && !o_result.data.near_valid) |-> (o_result.data.near_x == 0 && o_result.data.near_y == 0 && o_result.data.near_z == 0)), "closest point not cleared")

endmodule

>>> hw/rtl/bsq_front.sv
// ----------------------------------------------------------------------------
// bsq_front
// Offset, per-axis excess, squares and their sum: four register stages.
// ----------------------------------------------------------------------------
module bsq_front (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_en,
    input  bsq_pkg::t_ctl                                       i_ctl,
    input  logic [bsq_pkg::NUM_AXES-1:0][bsq_pkg::COORD_W-1:0] i_point,
    input  logic [bsq_pkg::NUM_AXES-1:0][bsq_pkg::COORD_W-1:0] i_center,
    input  logic [bsq_pkg::NUM_AXES-1:0][bsq_pkg::HALF_W-1:0]  i_half,
    output bsq_pkg::t_ctl                                       o_ctl,
    output bsq_pkg::t_side                                      o_side,
    output logic [bsq_pkg::SUM_W-1:0]                           o_sum
);
    import bsq_pkg::*;

    t_ctl r1_ctl, r2_ctl, r3_ctl, r4_ctl, n3_ctl;
    logic [NUM_AXES-1:0][P_W-1:0]     r1_p, r2_p, r3_p, r4_p, n1_p;
    logic [NUM_AXES-1:0][P_W-1:0]     r2_q, n2_q;
    logic [NUM_AXES-1:0][COORD_W-1:0] r3_o, r4_o, n3_o;
    logic [NUM_AXES-1:0][SQ_W-1:0]    r3_sq, n3_sq;
    logic [COORD_W-1:0]               r3_dq, r4_dq;
    logic [SUM_W-1:0]                 r4_sum;
    logic [P_W-1:0]                   abs_p;
    logic [AXIS_W-1:0]                sel_axis;

    // offset from the centre
    always_comb begin
        for (int k = 0; k < NUM_AXES; k++) begin
            n1_p[k] = {i_point[k][COORD_W-1], i_point[k]}
                    - {i_center[k][COORD_W-1], i_center[k]};
        end
    end

    // excess over the half extent
    always_comb begin
        abs_p = '0;
        for (int k = 0; k < NUM_AXES; k++) begin
            abs_p   = r1_p[k][P_W-1] ? (~r1_p[k] + P_W'(1)) : r1_p[k];
            n2_q[k] = abs_p - P_W'(i_half[k]);
        end
    end

    // clamp, squares, largest excess axis
    always_comb begin
        sel_axis = AXIS_X;
        if ($signed(r2_q[AXIS_Y]) > $signed(r2_q[AXIS_X])) sel_axis = AXIS_Y;
        if ($signed(r2_q[AXIS_Z]) > $signed(r2_q[sel_axis])) sel_axis = AXIS_Z;
        n3_ctl         = r2_ctl;
        n3_ctl.axis    = sel_axis;
        n3_ctl.outside = 1'b0;
        for (int k = 0; k < NUM_AXES; k++) begin
            if ($signed(r2_q[k]) > 0) begin
                n3_o[k]        = r2_q[k][COORD_W-1:0];
                n3_ctl.outside = 1'b1;
            end else begin
                n3_o[k] = '0;
            end
            n3_sq[k] = n3_o[k] * n3_o[k];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl.valid <= 1'b0;
            r2_ctl.valid <= 1'b0;
            r3_ctl.valid <= 1'b0;
            r4_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r1_ctl <= i_ctl;
            r2_ctl <= r1_ctl;
            r3_ctl <= n3_ctl;
            r4_ctl <= r3_ctl;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_p   <= n1_p;
            r2_p   <= r1_p;
            r2_q   <= n2_q;
            r3_p   <= r2_p;
            r3_o   <= n3_o;
            r3_sq  <= n3_sq;
            r3_dq  <= r2_q[sel_axis][COORD_W-1:0];
            r4_p   <= r3_p;
            r4_o   <= r3_o;
            r4_dq  <= r3_dq;
            r4_sum <= SUM_W'(r3_sq[AXIS_X]) + SUM_W'(r3_sq[AXIS_Y])
                    + SUM_W'(r3_sq[AXIS_Z]);
        end
    end

    assign o_ctl     = r4_ctl;
    assign o_side.p  = r4_p;
    assign o_side.o  = r4_o;
    assign o_side.dq = r4_dq;
    assign o_sum     = r4_sum;

endmodule

>>> hw/rtl/bsq_root_cell.sv
// ----------------------------------------------------------------------------
// bsq_root_cell
// One bit of the digit-by-digit square root of the sum of squares.
// ----------------------------------------------------------------------------
module bsq_root_cell #(
    parameter int BIT = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  bsq_pkg::t_ctl               i_ctl,
    input  bsq_pkg::t_side              i_side,
    input  logic [bsq_pkg::SUM_W-1:0]   i_rem,
    input  logic [bsq_pkg::ROOT_W-1:0]  i_root,
    output bsq_pkg::t_ctl               o_ctl,
    output bsq_pkg::t_side              o_side,
    output logic [bsq_pkg::SUM_W-1:0]   o_rem,
    output logic [bsq_pkg::ROOT_W-1:0]  o_root
);
    import bsq_pkg::*;

    localparam int TW = SUM_W + 1;

    t_ctl                r_ctl;
    t_side               r_side;
    logic [SUM_W-1:0]    r_rem, n_rem;
    logic [ROOT_W-1:0]   r_root, n_root;
    logic [TW-1:0]       trial;
    logic                fits;

    // (r + 2^b)^2 - r^2 against what is left
    always_comb begin
        trial  = (TW'(i_root) << (BIT + 1)) + (TW'(1) << (2 * BIT));
        fits   = TW'(i_rem) >= trial;
        n_rem  = fits ? SUM_W'(TW'(i_rem) - trial) : i_rem;
        n_root = fits ? (i_root | (ROOT_W'(1) << BIT)) : i_root;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_side = r_side;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

>>> hw/rtl/bsq_div_cell.sv
// ----------------------------------------------------------------------------
// bsq_div_cell
// One quotient bit of excess over norm, for all three axes at once.
// ----------------------------------------------------------------------------
module bsq_div_cell #(
    parameter bit FIRST = 1'b0
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_en,
    input  bsq_pkg::t_ctl                                     i_ctl,
    input  bsq_pkg::t_side                                    i_side,
    input  logic [bsq_pkg::ROOT_W-1:0]                        i_n,
    input  logic [bsq_pkg::NUM_AXES-1:0][bsq_pkg::REM_W-1:0]  i_rem,
    input  logic [bsq_pkg::NUM_AXES-1:0][bsq_pkg::ACC_W-1:0]  i_acc,
    output bsq_pkg::t_ctl                                     o_ctl,
    output bsq_pkg::t_side                                    o_side,
    output logic [bsq_pkg::ROOT_W-1:0]                        o_n,
    output logic [bsq_pkg::NUM_AXES-1:0][bsq_pkg::REM_W-1:0]  o_rem,
    output logic [bsq_pkg::NUM_AXES-1:0][bsq_pkg::ACC_W-1:0]  o_acc
);
    import bsq_pkg::*;

    t_ctl                             r_ctl;
    t_side                            r_side;
    logic [ROOT_W-1:0]                r_n;
    logic [NUM_AXES-1:0][REM_W-1:0]   r_rem, n_rem;
    logic [NUM_AXES-1:0][ACC_W-1:0]   r_acc, n_acc;
    logic [REM_W-1:0]                 t;
    logic                             q_bit;

    // restoring step per axis; the first cell starts from the excess itself
    always_comb begin
        t     = '0;
        q_bit = 1'b0;
        for (int k = 0; k < NUM_AXES; k++) begin
            t        = FIRST ? REM_W'(i_side.o[k]) : {i_rem[k][REM_W-2:0], 1'b0};
            q_bit    = t >= REM_W'(i_n);
            n_rem[k] = q_bit ? (t - REM_W'(i_n)) : t;
            n_acc[k] = FIRST ? ACC_W'(q_bit) : {i_acc[k][ACC_W-2:0], q_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_n    <= i_n;
            r_rem  <= n_rem;
            r_acc  <= n_acc;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_side = r_side;
    assign o_n    = r_n;
    assign o_rem  = r_rem;
    assign o_acc  = r_acc;

endmodule

>>> hw/rtl/bsq_back.sv
// ----------------------------------------------------------------------------
// bsq_back
// Distance select, gradient signs and closest point, into the output register.
// ----------------------------------------------------------------------------
module bsq_back (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_en,
    input  bsq_pkg::t_ctl                                       i_ctl,
    input  bsq_pkg::t_side                                      i_side,
    input  logic [bsq_pkg::ROOT_W-1:0]                          i_n,
    input  logic [bsq_pkg::NUM_AXES-1:0][bsq_pkg::REM_W-1:0]    i_rem,
    input  logic [bsq_pkg::NUM_AXES-1:0][bsq_pkg::ACC_W-1:0]    i_acc,
    input  logic [bsq_pkg::NUM_AXES-1:0][bsq_pkg::COORD_W-1:0]  i_center,
    input  logic [bsq_pkg::NUM_AXES-1:0][bsq_pkg::HALF_W-1:0]   i_half,
    output logic                                                o_valid,
    output bsq_pkg::t_result                                    o_data
);
    import bsq_pkg::*;

    logic                              r_valid;
    t_result                           r_res, n_res;
    logic [NUM_AXES-1:0][GRAD_W-1:0]   g;
    logic [NUM_AXES-1:0][COORD_W-1:0]  near;
    logic [ACC_W-1:0]                  mag;
    logic [GRAD_W-1:0]                 gm;
    logic [P_W-1:0]                    h_s, cl, pk, pa;
    logic [COORD_W+1:0]                v;
    logic [COORD_W-1:0]                dist_sel;

    always_comb begin
        mag  = '0;
        gm   = '0;
        h_s  = '0;
        cl   = '0;
        pk   = '0;
        v    = '0;
        pa   = i_side.p[i_ctl.axis];

        // distance
        if (i_ctl.outside) begin
            dist_sel = (i_n > ROOT_W'(C_MAX)) ? C_MAX : i_n[COORD_W-1:0];
        end else begin
            dist_sel = i_side.dq;
        end

        // gradient: rounded ratio outside, largest axis inside
        g = '0;
        if (i_ctl.outside) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                mag  = i_acc[k]
                     + ACC_W'({i_rem[k], 1'b0} >= (REM_W + 1)'(i_n));
                gm   = GRAD_W'(mag);
                g[k] = i_side.p[k][P_W-1] ? (~gm + GRAD_W'(1)) : gm;
            end
        end else if (pa == '0) begin
            g[AXIS_X] = GRAD_W'(GRAD_ONE);
        end else begin
            g[i_ctl.axis] = pa[P_W-1] ? (~GRAD_W'(GRAD_ONE) + GRAD_W'(1))
                                      : GRAD_W'(GRAD_ONE);
        end
        if (!i_ctl.want_grad) g = '0;

        // closest point with saturation
        for (int k = 0; k < NUM_AXES; k++) begin
            h_s = P_W'(i_half[k]);
            pk  = i_side.p[k];
            cl  = pk;
            if (i_ctl.outside) begin
                if ($signed(pk) > $signed(h_s)) cl = h_s;
                if ($signed(pk) < -$signed(h_s)) cl = ~h_s + P_W'(1);
            end else if (i_ctl.axis == AXIS_W'(k)) begin
                cl = pk[P_W-1] ? (~h_s + P_W'(1)) : h_s;
            end
            v = {{2{i_center[k][COORD_W-1]}}, i_center[k]} + {cl[P_W-1], cl};
            if ($signed(v) > $signed({2'b00, C_MAX})) begin
                near[k] = C_MAX;
            end else if ($signed(v) < $signed({2'b11, C_MIN})) begin
                near[k] = C_MIN;
            end else begin
                near[k] = v[COORD_W-1:0];
            end
        end
        if (!i_ctl.want_near) near = '0;

        n_res.distance   = dist_sel;
        n_res.grad_x     = g[AXIS_X];
        n_res.grad_y     = g[AXIS_Y];
        n_res.grad_z     = g[AXIS_Z];
        n_res.near_x     = near[AXIS_X];
        n_res.near_y     = near[AXIS_Y];
        n_res.near_z     = near[AXIS_Z];
        n_res.near_valid = i_ctl.want_near;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_res;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Box distance queries checked against an in-bench predictor or listed
// values. A directed table comes first, then random queries under several
// box settings, with random gaps on both the query and the result side.
// ----------------------------------------------------------------------------
module testbench;
    import bsq_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [COORD_W-1:0] i_cfg_data = '0;

    bsq_stream_if #(.t_data(t_query))  query_if ();
    bsq_stream_if #(.t_data(t_result)) result_if ();

    box_sdf_query dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_query(query_if.sink), .o_result(result_if.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    localparam int LATENCY = 54;
    localparam int WATCHDOG_LIMIT = 2000;

    always #1 i_clk = ~i_clk;

    // box held by the predictor
    logic signed [COORD_W-1:0] box_centre [3];
    logic [HALF_W-1:0] box_half [3];

    t_result expected_q [$];
    int errors = 0;
    int n_results = 0;
    int n_queries = 0;
    int idle_cycles = 0;
    bit stim_done = 0;

    // directed rows
    typedef struct {
        t_query  qry;
        bit      has_exp;
        t_result res;
    } t_row;

    // ---- predictor ----
    function automatic logic [63:0] isqrt_round(logic [127:0] s);
        logic [63:0] r;
        logic [63:0] c;
        logic [127:0] rr;
        r = '0;
        for (int b = 50; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= s) r = c;
        end
        rr = 128'(r) * 128'(r);
        if (s - rr > 128'(r)) r++;
        return r;
    endfunction

    function automatic logic [63:0] grad_ratio(logic [63:0] o, logic [63:0] n);
        logic [63:0] acc;
        logic [63:0] rem;
        acc = (o >= n) ? 64'd1 : 64'd0;
        rem = o - acc * n;
        for (int i = 0; i < GRAD_FRAC; i++) begin
            rem = rem << 1;
            acc = acc << 1;
            if (rem >= n) begin
                rem -= n;
                acc |= 64'd1;
            end
        end
        rem = rem << 1;
        if (rem >= n) acc++;
        return acc;
    endfunction

    function automatic t_result box_distance(t_query qy);
        t_result r;
        longint p[3], q[3], c[3], h[3], g[3], cl, v, sdist;
        logic [63:0] o[3];
        logic [127:0] s;
        logic [63:0] n;
        bit outside;
        int axis;
        longint cmax, cmin;
        cmax = 64'h7fffffff;
        cmin = -cmax - 1;
        outside = 0;
        axis = 0;
        s = '0;
        n = '0;
        r = '0;
        for (int i = 0; i < 3; i++) begin
            c[i] = longint'(box_centre[i]);
            h[i] = longint'({1'b0, box_half[i]});
            p[i] = (i == 0 ? longint'(qy.point_x) : i == 1 ? longint'(qy.point_y)
                    : longint'(qy.point_z)) - c[i];
            q[i] = (p[i] < 0 ? -p[i] : p[i]) - h[i];
            o[i] = q[i] > 0 ? q[i] : 0;
            if (q[i] > 0) outside = 1;
            if (q[i] > q[axis]) axis = i;
            s += 128'(o[i]) * 128'(o[i]);
        end
        if (outside) begin
            n = isqrt_round(s);
            sdist = (n > 64'(cmax)) ? cmax : longint'(n);
        end else begin
            sdist = q[axis];
        end
        r.distance = sdist[COORD_W-1:0];
        if (qy.want_gradient) begin
            g[0] = 0; g[1] = 0; g[2] = 0;
            if (outside) begin
                for (int i = 0; i < 3; i++) begin
                    v = longint'(grad_ratio(o[i], n));
                    g[i] = p[i] < 0 ? -v : v;
                end
            end else if (p[axis] == 0) begin
                g[0] = GRAD_ONE;
            end else begin
                g[axis] = p[axis] < 0 ? -GRAD_ONE : GRAD_ONE;
            end
            r.grad_x = g[0][GRAD_W-1:0];
            r.grad_y = g[1][GRAD_W-1:0];
            r.grad_z = g[2][GRAD_W-1:0];
        end
        if (qy.want_closest) begin
            for (int i = 0; i < 3; i++) begin
                cl = p[i];
                if (outside) begin
                    if (cl > h[i]) cl = h[i];
                    if (cl < -h[i]) cl = -h[i];
                end else if (i == axis) begin
                    cl = p[i] >= 0 ? h[i] : -h[i];
                end
                v = c[i] + cl;
                if (v > cmax) v = cmax;
                if (v < cmin) v = cmin;
                if (i == 0) r.near_x = v[COORD_W-1:0];
                else if (i == 1) r.near_y = v[COORD_W-1:0];
                else r.near_z = v[COORD_W-1:0];
            end
            r.near_valid = 1'b1;
        end
        return r;
    endfunction

    // ---- configuration ----
    task automatic write_reg(t_reg_idx idx, logic [COORD_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx <= REG_CENTER_Z) box_centre[idx] = val;
        else box_half[idx - REG_HALF_X] = val[HALF_W-1:0];
    endtask

    task automatic set_box(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                           logic [COORD_W-1:0] cz, logic [COORD_W-1:0] hx,
                           logic [COORD_W-1:0] hy, logic [COORD_W-1:0] hz);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_HALF_X, hx);
        write_reg(REG_HALF_Y, hy);
        write_reg(REG_HALF_Z, hz);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        query_if.valid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    // ---- query driver ----
    // entered at a falling edge; valid stays high after a beat until the
    // next gap or drain lowers it
    task automatic send_query(t_query qy, bit has_exp, t_result res);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            query_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        query_if.valid <= 1'b1;
        query_if.data <= qy;
        expected_q.push_back(has_exp ? res : box_distance(qy));
        @(posedge i_clk);
        while (!query_if.ready) @(posedge i_clk);
        n_queries++;
        @(negedge i_clk);
    endtask

    function automatic logic [COORD_W-1:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            2: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 255)
                                          : 32'h80000000 + $urandom_range(0, 255);
            default: return 32'($signed($urandom_range(0, 512)) - 256);
        endcase
    endfunction

    function automatic t_query rand_query(int mode);
        t_query qy;
        qy.point_x = rand_coord($urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : mode);
        qy.point_y = rand_coord($urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : mode);
        qy.point_z = rand_coord($urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : mode);
        qy.want_gradient = $urandom_range(0, 1);
        qy.want_closest = $urandom_range(0, 1);
        return qy;
    endfunction

    // ---- result checker ----
    always @(posedge i_clk) begin
        t_result got;
        t_result exp_r;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            got = result_if.data;
            if (expected_q.size() == 0) begin
                $display("%0t: result with nothing expected, actual %h", $time, got);
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                n_results++;
                if (got.distance !== exp_r.distance)
                    $display("%0t: distance expected %h actual %h", $time,
                             exp_r.distance, got.distance);
                if (got.grad_x !== exp_r.grad_x)
                    $display("%0t: grad_x expected %h actual %h", $time,
                             exp_r.grad_x, got.grad_x);
                if (got.grad_y !== exp_r.grad_y)
                    $display("%0t: grad_y expected %h actual %h", $time,
                             exp_r.grad_y, got.grad_y);
                if (got.grad_z !== exp_r.grad_z)
                    $display("%0t: grad_z expected %h actual %h", $time,
                             exp_r.grad_z, got.grad_z);
                if (got.near_x !== exp_r.near_x)
                    $display("%0t: near_x expected %h actual %h", $time,
                             exp_r.near_x, got.near_x);
                if (got.near_y !== exp_r.near_y)
                    $display("%0t: near_y expected %h actual %h", $time,
                             exp_r.near_y, got.near_y);
                if (got.near_z !== exp_r.near_z)
                    $display("%0t: near_z expected %h actual %h", $time,
                             exp_r.near_z, got.near_z);
                if (got.near_valid !== exp_r.near_valid)
                    $display("%0t: near_valid expected %b actual %b", $time,
                             exp_r.near_valid, got.near_valid);
                if (got !== exp_r) errors++;
            end
        end
    end

    // ---- result side stalls ----
    initial begin
        int stall;
        result_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                @(negedge i_clk);
                result_if.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            result_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!result_if.valid) @(posedge i_clk);
        end
    end

    // ---- watchdog ----
    always @(posedge i_clk) begin
        if ((query_if.valid && query_if.ready) || (result_if.valid && result_if.ready))
            idle_cycles <= 0;
        else if (i_rst_n && !(stim_done && expected_q.size() == 0))
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d beats still expected", $time,
                     expected_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ---- stimulus ----
    initial begin
        t_row rows [$];
        t_row rw;
        t_result zr;
        int mode;
        query_if.valid = 1'b0;
        query_if.data = '0;
        for (int i = 0; i < 3; i++) begin
            box_centre[i] = '0;
            box_half[i] = HALF_RESET;
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table on the reset box (cube of half extent 1.0 at origin)
        zr = '0;
        // centre: inside, tie on all axes, zero offset falls back to +x
        rw.qry = '{32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b1}; rw.has_exp = 1;
        rw.res = zr; rw.res.distance = -32'sd65536; rw.res.grad_x = 16'sd16384;
        rw.res.near_x = 32'sd65536; rw.res.near_valid = 1'b1; rows.push_back(rw);
        // outside along +x by 1.0
        rw.qry = '{32'sd131072, 32'sd0, 32'sd0, 1'b1, 1'b1};
        rw.res = zr; rw.res.distance = 32'sd65536; rw.res.grad_x = 16'sd16384;
        rw.res.near_x = 32'sd65536; rw.res.near_valid = 1'b1; rows.push_back(rw);
        // outside along -z, nothing requested
        rw.qry = '{32'sd0, 32'sd0, -32'sd196608, 1'b0, 1'b0};
        rw.res = zr; rw.res.distance = 32'sd131072; rows.push_back(rw);
        // on the surface
        rw.qry = '{32'sd0, -32'sd65536, 32'sd0, 1'b1, 1'b0};
        rw.res = zr; rw.res.grad_y = -16'sd16384; rows.push_back(rw);
        rw.has_exp = 0;
        // extremes of the coordinate range, then further rows left to the predictor
        rw.qry = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1, 1'b1}; rows.push_back(rw);
        rw.qry = '{32'h80000000, 32'h80000000, 32'h80000000, 1'b1, 1'b1}; rows.push_back(rw);
        rw.qry = '{32'h80000000, 32'h7fffffff, 32'sd0, 1'b1, 1'b1}; rows.push_back(rw);
        rw.qry = '{32'sd70000, 32'sd70000, -32'sd70000, 1'b1, 1'b1}; rows.push_back(rw);
        rw.qry = '{-32'sd1000, 32'sd30000, 32'sd30000, 1'b1, 1'b1}; rows.push_back(rw);
        rw.qry = '{32'sd0, 32'sd0, -32'sd1, 1'b1, 1'b1}; rows.push_back(rw);
        rw.qry = '{32'sd5, 32'sd5, 32'sd0, 1'b1, 1'b0}; rows.push_back(rw);
        foreach (rows[i]) send_query(rows[i].qry, rows[i].has_exp, rows[i].res);

        // hold off until every result is back, then move to degenerate and huge boxes
        drain();
        set_box(32'h7fffffff, 32'h80000000, 32'h0, 32'h0, 32'h0, 32'h0);
        for (int i = 0; i < 8; i++) send_query(rand_query(i % 4), 0, zr);
        drain();
        set_box(32'h80000000, 32'h7fffffff, 32'h12345, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff);
        for (int i = 0; i < 8; i++) send_query(rand_query(i % 4), 0, zr);

        // random phases, each with a fresh box
        for (int ph = 0; ph < 10; ph++) begin
            drain();
            mode = ph % 4;
            set_box(rand_coord(mode == 2 ? 0 : mode), rand_coord(mode == 2 ? 0 : mode),
                    rand_coord(mode == 2 ? 0 : mode),
                    ph == 3 ? 32'h0 : $urandom_range(0, 3 << 16),
                    $urandom_range(0, 1) ? $urandom() & 32'h7fffffff
                                         : $urandom_range(0, 3 << 16),
                    $urandom_range(0, 3 << 16));
            for (int i = 0; i < 108; i++)
                send_query(rand_query($urandom_range(0, 2) == 0 ? 0 : (mode == 2 ? 1 : mode)),
                           0, zr);
        end

        drain();
        stim_done = 1;
        $display("covered %0d queries over 13 box settings incl. degenerate and full-range",
                 n_queries);
        $display("%0d results compared, %0d mismatching", n_results, errors);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/bsq_pkg.sv
hw/rtl/bsq_stream_if.sv
hw/rtl/bsq_front.sv
hw/rtl/bsq_root_cell.sv
hw/rtl/bsq_div_cell.sv
hw/rtl/bsq_back.sv
hw/rtl/box_sdf_query.sv
tb/testbench.sv
